// File: hdl/pressure_sensor_compensation_macros.svh
// Assertion macros shared by the pressure sensor compensation RTL.
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define PSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define PSC_ASSERT_IMP(lbl, ante, cons, msg) \
  `PSC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: hdl/psc_pkg.sv
// Package: widths, payload structs and register indexes of the pressure compensation block.
`default_nettype none

package psc_pkg;

  localparam int unsigned D_W       = 24;  // raw conversion width
  localparam int unsigned CAL_W     = 16;  // calibration word width
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TEMP_W    = 19;  // compensated temperature
  localparam int unsigned PRES_W    = 32;  // compensated pressure
  localparam int unsigned SENS_W    = 36;  // first-order SENS / OFF
  localparam int unsigned SQ_W      = 36;  // squared temperature deltas
  localparam int unsigned CORR_W    = 40;  // second-order OFFi / SENSi
  localparam int unsigned SENS2_W   = 41;  // corrected SENS2 / OFF2
  localparam int unsigned N_W       = 31;  // pressure before the divide by ten

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } psc_reg_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coeff;
  } psc_cal_t;

  typedef struct packed {
    logic [D_W-1:0] raw_pressure;
    logic [D_W-1:0] raw_temperature;
  } psc_in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [PRES_W-1:0] pressure;
  } psc_out_t;

  // Temperature front end to pressure back end.
  typedef struct packed {
    logic [D_W-1:0]           d1;
    logic signed [TEMP_W-1:0] temp2;
    logic signed [SENS_W-1:0] sens;
    logic signed [SENS_W-1:0] off;
    logic [SQ_W-1:0]          sql;    // (TEMP-2000)^2
    logic [SQ_W-1:0]          sqv;    // (TEMP+1500)^2
    logic                     low;    // TEMP < 2000
    logic                     vlow;   // TEMP < -1500
  } psc_t2p_t;

  // Pressure back end to divide-by-ten stage.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp2;
    logic signed [N_W-1:0]    n;
  } psc_p2d_t;

endpackage

`default_nettype wire

// File: hdl/psc_cfg.sv
// Calibration word registers written through the configuration port.
`default_nettype none

module psc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0] idx_i,
  input  wire logic [psc_pkg::CAL_W-1:0]     wdata_i,
  output psc_pkg::psc_cal_t                  cal_o
);
  import psc_pkg::*;

  psc_cal_t cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (we_i) begin
      unique case (idx_i)
        REG_PRESSURE_SENSITIVITY:   cal_q.pressure_sensitivity   <= wdata_i;
        REG_PRESSURE_OFFSET:        cal_q.pressure_offset        <= wdata_i;
        REG_SENSITIVITY_TEMP_COEFF: cal_q.sensitivity_temp_coeff <= wdata_i;
        REG_OFFSET_TEMP_COEFF:      cal_q.offset_temp_coeff      <= wdata_i;
        REG_REFERENCE_TEMPERATURE:  cal_q.reference_temperature  <= wdata_i;
        REG_TEMPERATURE_COEFF:      cal_q.temperature_coeff      <= wdata_i;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cal_o = cal_q;

endmodule

`default_nettype wire

// File: hdl/psc_temp.sv
// Temperature front end: dT, first-order SENS/OFF, TEMP2 and squared deltas (4 stages).
`default_nettype none

module psc_temp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire psc_pkg::psc_cal_t cal_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire psc_pkg::psc_in_t  data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output psc_pkg::psc_t2p_t      data_o
);
  import psc_pkg::*;

  localparam int unsigned STAGES = 4;

  logic [STAGES-1:0] v_q, v_d, en;

  always_comb begin
    en[STAGES-1] = !v_q[STAGES-1] || ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_d     = {v_q[STAGES-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_d) | (~en & v_q);
    end
  end

  // Stage 1: dT = D2 - C5*256
  logic signed [D_W:0] dt_d, dt_q;
  logic [D_W-1:0]      d1_s1_q;

  assign dt_d = $signed({1'b0, data_i.raw_temperature})
              - $signed({1'b0, cal_i.reference_temperature, 8'b0});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dt_q    <= dt_d;
      d1_s1_q <= data_i.raw_pressure;
    end
  end

  // Stage 2: the four products of dT
  logic signed [41:0] m6_d, m3_d, m4_d, m6_q, m3_q, m4_q;
  logic signed [49:0] dtsq_full;
  logic [48:0]        dtsq_q;
  logic [D_W-1:0]     d1_s2_q;

  assign m6_d      = dt_q * $signed({1'b0, cal_i.temperature_coeff});
  assign m3_d      = dt_q * $signed({1'b0, cal_i.sensitivity_temp_coeff});
  assign m4_d      = dt_q * $signed({1'b0, cal_i.offset_temp_coeff});
  assign dtsq_full = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      m6_q    <= m6_d;
      m3_q    <= m3_d;
      m4_q    <= m4_d;
      dtsq_q  <= dtsq_full[48:0];
      d1_s2_q <= d1_s1_q;
    end
  end

  // Stage 3: truncating shifts, TEMP, SENS, OFF, Ti
  logic signed [41:0]       q6_w, q3_w, q4_w;
  logic signed [TEMP_W-1:0] dlow_d, dvl_d, temp_d, dlow_q, dvl_q, temp_q;
  logic signed [SENS_W-1:0] sens_d, off_d, sens_q, off_q;
  logic [50:0]              dtsq_x3;
  logic [17:0]              ti_d, ti_q;
  logic [D_W-1:0]           d1_s3_q;

  // negative values get 2^k-1 added before the shift to round toward zero
  assign q6_w = (m6_q + (m6_q[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
  assign q3_w = (m3_q + (m3_q[41] ? 42'sd255 : 42'sd0)) >>> 8;
  assign q4_w = (m4_q + (m4_q[41] ? 42'sd127 : 42'sd0)) >>> 7;

  assign dlow_d = q6_w[TEMP_W-1:0];           // TEMP - 2000
  assign temp_d = dlow_d + 19'sd2000;
  assign dvl_d  = dlow_d + 19'sd3500;          // TEMP + 1500
  assign sens_d = $signed({5'b0, cal_i.pressure_sensitivity, 15'b0})
                + $signed(q3_w[SENS_W-1:0]);
  assign off_d  = $signed({4'b0, cal_i.pressure_offset, 16'b0})
                + $signed(q4_w[SENS_W-1:0]);

  assign dtsq_x3 = {2'b0, dtsq_q} + {1'b0, dtsq_q, 1'b0};
  // low band 3*dT^2/2^33, high band 2*dT^2/2^37 = dT^2/2^36
  assign ti_d = dlow_d[TEMP_W-1] ? dtsq_x3[50:33] : {5'b0, dtsq_q[48:36]};

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dlow_q  <= dlow_d;
      dvl_q   <= dvl_d;
      temp_q  <= temp_d;
      sens_q  <= sens_d;
      off_q   <= off_d;
      ti_q    <= ti_d;
      d1_s3_q <= d1_s2_q;
    end
  end

  // Stage 4: squared deltas and TEMP2
  logic signed [37:0] sql_full, sqv_full;
  psc_t2p_t           out_d, out_q;

  assign sql_full = dlow_q * dlow_q;
  assign sqv_full = dvl_q * dvl_q;

  always_comb begin
    out_d.d1    = d1_s3_q;
    out_d.temp2 = temp_q - $signed({1'b0, ti_q});
    out_d.sens  = sens_q;
    out_d.off   = off_q;
    out_d.sql   = sql_full[SQ_W-1:0];
    out_d.sqv   = sqv_full[SQ_W-1:0];
    out_d.low   = dlow_q[TEMP_W-1];
    out_d.vlow  = dvl_q[TEMP_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

endmodule

`default_nettype wire

// File: hdl/psc_press.sv
// Pressure back end: second-order corrections, D1*SENS2 and scaling (6 stages).
`default_nettype none

module psc_press (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire psc_pkg::psc_t2p_t data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output psc_pkg::psc_p2d_t      data_o
);
  import psc_pkg::*;

  localparam int unsigned STAGES = 6;
  localparam int unsigned LO_W   = 20;  // low part of SENS2 for the split product
  localparam int unsigned HI_W   = SENS2_W - LO_W;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned P_W    = 44;

  logic [STAGES-1:0] v_q, v_d, en;

  always_comb begin
    en[STAGES-1] = !v_q[STAGES-1] || ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_d     = {v_q[STAGES-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_d) | (~en & v_q);
    end
  end

  // Stage 1: OFFi / SENSi by band
  logic [37:0]              sql_x3, sql_x5;
  logic [38:0]              sqv_x7;
  logic [CORR_W-1:0]        offi_d, sensi_d, offi_q, sensi_q;
  logic signed [SENS_W-1:0] sens_s1_q, off_s1_q;
  logic signed [TEMP_W-1:0] temp2_s1_q;
  logic [D_W-1:0]           d1_s1_q;

  assign sql_x3 = {1'b0, data_i.sql, 1'b0} + {2'b0, data_i.sql};
  assign sql_x5 = {data_i.sql, 2'b0} + {2'b0, data_i.sql};
  assign sqv_x7 = {data_i.sqv, 3'b0} - {3'b0, data_i.sqv};

  always_comb begin
    if (data_i.low) begin
      offi_d  = CORR_W'(sql_x3 >> 1);
      sensi_d = CORR_W'(sql_x5 >> 3);
      if (data_i.vlow) begin
        offi_d  = offi_d + CORR_W'(sqv_x7);
        sensi_d = sensi_d + CORR_W'({data_i.sqv, 2'b0});
      end
    end else begin
      offi_d  = CORR_W'(data_i.sql >> 4);
      sensi_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      offi_q     <= offi_d;
      sensi_q    <= sensi_d;
      sens_s1_q  <= data_i.sens;
      off_s1_q   <= data_i.off;
      temp2_s1_q <= data_i.temp2;
      d1_s1_q    <= data_i.d1;
    end
  end

  // Stage 2: OFF2, SENS2
  logic signed [SENS2_W-1:0] off2_d, sens2_d, off2_s2_q, sens2_q;
  logic signed [TEMP_W-1:0]  temp2_s2_q;
  logic [D_W-1:0]            d1_s2_q;

  assign off2_d  = SENS2_W'(off_s1_q) - $signed({1'b0, offi_q});
  assign sens2_d = SENS2_W'(sens_s1_q) - $signed({1'b0, sensi_q});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      off2_s2_q  <= off2_d;
      sens2_q    <= sens2_d;
      temp2_s2_q <= temp2_s1_q;
      d1_s2_q    <= d1_s1_q;
    end
  end

  // Stage 3: D1*SENS2 as two partial products
  logic [D_W+LO_W-1:0]          pp_lo_d, pp_lo_q;
  logic signed [D_W+HI_W:0]     pp_hi_d, pp_hi_q;
  logic signed [SENS2_W-1:0]    off2_s3_q;
  logic signed [TEMP_W-1:0]     temp2_s3_q;

  assign pp_lo_d = d1_s2_q * sens2_q[LO_W-1:0];
  assign pp_hi_d = $signed({1'b0, d1_s2_q}) * $signed(sens2_q[SENS2_W-1:LO_W]);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pp_lo_q    <= pp_lo_d;
      pp_hi_q    <= pp_hi_d;
      off2_s3_q  <= off2_s2_q;
      temp2_s3_q <= temp2_s2_q;
    end
  end

  // Stage 4: recombine the product
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [SENS2_W-1:0] off2_s4_q;
  logic signed [TEMP_W-1:0]  temp2_s4_q;

  assign prod_d = (PROD_W'(pp_hi_q) <<< LO_W)
                + $signed({{(PROD_W-D_W-LO_W){1'b0}}, pp_lo_q});

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      prod_q     <= prod_d;
      off2_s4_q  <= off2_s3_q;
      temp2_s4_q <= temp2_s3_q;
    end
  end

  // Stage 5: D1*SENS2/2^21 - OFF2
  logic signed [PROD_W-1:0] t21_w;
  logic signed [P_W-1:0]    p_d, p_q;
  logic signed [TEMP_W-1:0] temp2_s5_q;

  assign t21_w = (prod_q + (prod_q[PROD_W-1] ? 64'sd2097151 : 64'sd0)) >>> 21;
  assign p_d   = P_W'($signed(t21_w[P_W-2:0])) - P_W'(off2_s4_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p_q        <= p_d;
      temp2_s5_q <= temp2_s4_q;
    end
  end

  // Stage 6: /2^13 toward zero
  logic signed [P_W-1:0] t13_w;
  psc_p2d_t              out_d, out_q;

  assign t13_w = (p_q + (p_q[P_W-1] ? 44'sd8191 : 44'sd0)) >>> 13;

  always_comb begin
    out_d.temp2 = temp2_s5_q;
    out_d.n     = t13_w[N_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

endmodule

`default_nettype wire

// File: hdl/psc_div10.sv
// Signed divide by ten, truncating toward zero, via reciprocal multiply (3 stages).
`default_nettype none

`include "pressure_sensor_compensation_macros.svh"

module psc_div10 (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire psc_pkg::psc_p2d_t data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output psc_pkg::psc_out_t      data_o
);
  import psc_pkg::*;

  localparam int unsigned STAGES = 3;
  localparam int unsigned RP_W   = N_W + 32;
  localparam int unsigned Q_W    = RP_W - 35;
  // ceil(2^35/10): exact quotient for any 32-bit magnitude after >>35
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  logic [STAGES-1:0] v_q, v_d, en;

  always_comb begin
    en[STAGES-1] = !v_q[STAGES-1] || ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_d     = {v_q[STAGES-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_d) | (~en & v_q);
    end
  end

  // Stage 1: magnitude and sign
  logic [N_W-1:0]           mag_d, mag_s1_q, mag_s2_q, mag_s3_q;
  logic                     neg_s1_q, neg_s2_q, neg_s3_q;
  logic signed [TEMP_W-1:0] temp_s1_q, temp_s2_q;

  assign mag_d = data_i.n[N_W-1] ? N_W'(-data_i.n) : N_W'(data_i.n);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag_s1_q  <= mag_d;
      neg_s1_q  <= data_i.n[N_W-1];
      temp_s1_q <= data_i.temp2;
    end
  end

  // Stage 2: reciprocal product
  logic [RP_W-1:0] rp_d, rp_q;

  assign rp_d = mag_s1_q * RECIP10;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rp_q      <= rp_d;
      mag_s2_q  <= mag_s1_q;
      neg_s2_q  <= neg_s1_q;
      temp_s2_q <= temp_s1_q;
    end
  end

  // Stage 3: quotient, sign restored, output register
  logic [Q_W-1:0] q_w, q_s3_q;
  psc_out_t       out_d, out_q;

  assign q_w = rp_q[RP_W-1:35];

  always_comb begin
    out_d.temperature = temp_s2_q;
    out_d.pressure    = neg_s2_q ? (PRES_W'(0) - PRES_W'(q_w)) : PRES_W'(q_w);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      out_q    <= out_d;
      q_s3_q   <= q_w;
      mag_s3_q <= mag_s2_q;
      neg_s3_q <= neg_s2_q;
    end
  end

  assign data_o = out_q;

  logic [31:0] q10_w, mag32_w;
  logic        quot_ok_w, sign_ok_w;
  assign q10_w     = 32'(q_s3_q) * 32'd10;
  assign mag32_w   = 32'(mag_s3_q);
  assign quot_ok_w = (q10_w <= mag32_w) && ((mag32_w - q10_w) < 32'd10);
  assign sign_ok_w = out_q.pressure[PRES_W-1] == (neg_s3_q && (q_s3_q != '0));

  `PSC_ASSERT_IMP(a_div10_exact, v_q[STAGES-1], quot_ok_w, "divide by ten quotient off")
  `PSC_ASSERT_IMP(a_div10_sign, v_q[STAGES-1], sign_ok_w, "divide by ten sign wrong")

endmodule

`default_nettype wire

// File: hdl/pressure_sensor_compensation.sv
// Top level: second-order temperature compensation for a 24-bit pressure sensor.
// One transfer of a raw pressure (D1) and raw temperature (D2) pair gives one transfer of
// compensated temperature (hundredths of a degree) and pressure. The pipeline takes a new
// pair every cycle while back-pressure from the output does not reach the input. There are
// 4 stages in the temperature front end (dT, the dT products, the truncating shifts, the
// squared deltas), 6 in the pressure back end (band corrections, OFF2/SENS2, D1*SENS2 as
// two partial products, recombination, /2^21 and /2^13) and 3 in the divide by ten
// (magnitude, reciprocal multiply, quotient). Each stage holds its own valid bit and only
// stalls when it is full and the stage below it cannot move, so bubbles close up and the
// input keeps taking pairs while a result waits at the output. Calibration words C1..C6
// sit at indexes 0..5 of the write port; other indexes are ignored. Write them only while
// the pipeline is empty. With 24-bit and 16-bit operands the scaled pressure fits in 30
// bits; there is no saturation: the quotient is widened to 32 bits and negated if negative.
`default_nettype none

`include "pressure_sensor_compensation_macros.svh"

module pressure_sensor_compensation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [psc_pkg::CAL_W-1:0]     cfg_wdata_i,
  // raw sample pairs
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire psc_pkg::psc_in_t              in_data_i,
  // compensated results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output psc_pkg::psc_out_t                  out_data_o
);
  import psc_pkg::*;

  psc_cal_t cal;
  psc_t2p_t t2p_data;
  psc_p2d_t p2d_data;
  logic     t2p_valid, t2p_ready;
  logic     p2d_valid, p2d_ready;
  logic     out_held;

  psc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cal_o   (cal)
  );

  // dT, TEMP2, first-order SENS/OFF
  psc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (t2p_valid),
    .ready_i (t2p_ready),
    .data_o  (t2p_data)
  );

  // second-order corrections and scaled pressure
  psc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t2p_valid),
    .ready_o (t2p_ready),
    .data_i  (t2p_data),
    .valid_o (p2d_valid),
    .ready_i (p2d_ready),
    .data_o  (p2d_data)
  );

  // final /10, also the output register
  psc_div10 u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2d_valid),
    .ready_o (p2d_ready),
    .data_i  (p2d_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  assign out_held = out_valid_o && !out_ready_i;

  // An empty output stage means every stage can move, so the input must be open.
  `PSC_ASSERT_IMP(a_ready_when_out_empty, !out_valid_o, in_ready_o, "input blocked, output empty")
  // Back-pressure only ever starts at a stalled output.
  `PSC_ASSERT_IMP(a_stall_from_output, !in_ready_o, out_held, "input stall not from output")

endmodule

`default_nettype wire
